[rtl/core/crms_pkg.sv]
// shared types and constants for the clutter map subtraction block
package crms_pkg;

	localparam int AZIMUTH_ROWS    = 512;
	localparam int SAMPLES_PER_ROW = 512;
	localparam int MAP_DEPTH       = AZIMUTH_ROWS * SAMPLES_PER_ROW;
	localparam int ADDR_W          = $clog2(MAP_DEPTH);

	localparam int SAMPLE_W  = 8;
	localparam int BIN_W     = 9;
	localparam int AZ_W      = 9;
	localparam int SIU_W     = 10;
	localparam int LCOUNT_W  = 16;

	localparam logic [SIU_W-1:0]    SIU_RESET    = 10'd512;
	localparam logic [LCOUNT_W-1:0] LCOUNT_RESET = 16'd3600;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// register index, taken from paddr[2]
	localparam logic REG_SAMPLES_IN_USE = 1'b0;
	localparam logic REG_LEARN_COUNT    = 1'b1;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [ADDR_W-1:0]   addr;
		logic                hit;
		logic                learn;
	} crms_item_t;

endpackage

[rtl/core/crms_front.sv]
// front end: learning controller, range check and map address
module crms_front
	import crms_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SAMPLE_W-1:0] sample_value,
	input  logic [BIN_W-1:0]    sample_index,
	input  logic [AZ_W-1:0]     azimuth,
	input  logic [AZ_W-1:0]     reported_bearing,
	input  logic                first_of_sweep,
	input  logic                set_learning,
	input  logic [SIU_W-1:0]    samples_in_use,
	input  logic [LCOUNT_W-1:0] learn_count,
	input  logic                clear_busy,
	input  logic                q_full,
	output logic                push,
	output crms_item_t          push_item
);

	logic                learn_q;
	logic [LCOUNT_W-1:0] count_q;
	logic [AZ_W-1:0]     prev_az_q;

	logic                learn_d;
	logic [LCOUNT_W-1:0] count_d;
	logic [LCOUNT_W-1:0] count_inc;
	logic                learn_req;
	logic                in_range;

	assign in_ready = !q_full && !clear_busy;
	assign push     = in_valid && in_ready;

	assign learn_req = learn_q || set_learning;
	assign count_inc = count_q + 16'd1;

	always_comb begin
		learn_d = learn_q;
		count_d = count_q;
		if (first_of_sweep) begin
			learn_d = learn_req;
			if (learn_req && (prev_az_q != reported_bearing)) begin
				if (count_inc >= learn_count) begin
					learn_d = 1'b0;
					count_d = '0;
				end else begin
					count_d = count_inc;
				end
			end
		end
	end

	assign in_range = ({1'b0, sample_index} < samples_in_use) &&
		(32'(sample_index) < SAMPLES_PER_ROW) &&
		(32'(azimuth) < AZIMUTH_ROWS);

	always_comb begin
		push_item.sample = sample_value;
		push_item.addr   = ADDR_W'(32'(azimuth) * SAMPLES_PER_ROW + 32'(sample_index));
		push_item.hit    = in_range;
		push_item.learn  = learn_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_q   <= 1'b0;
			count_q   <= '0;
			prev_az_q <= '0;
		end else if (push) begin
			learn_q <= learn_d;
			count_q <= count_d;
			if (first_of_sweep) begin
				prev_az_q <= azimuth;
			end
		end
	end

endmodule

[rtl/core/crms_queue.sv]
// short fifo between the front end and the map pipeline
module crms_queue
	import crms_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  crms_item_t push_item,
	output logic       full,
	input  logic       pop,
	output logic       not_empty,
	output crms_item_t head_item
);

	crms_item_t         slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign full      = (32'(count_q) == Q_DEPTH);
	assign not_empty = (count_q != '0);
	assign head_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == Q_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == Q_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/crms_back.sv]
// back end: clutter map read-modify-write, subtraction and output register
module crms_back
	import crms_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_not_empty,
	input  crms_item_t          q_head,
	output logic                pop,
	output logic                clear_busy,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SAMPLE_W-1:0] filtered_value,
	output logic                learning_active
);

	logic [SAMPLE_W-1:0] map_mem [MAP_DEPTH];

	logic                clr_busy_q;
	logic [ADDR_W-1:0]   clr_addr_q;

	logic                valid_s1;
	crms_item_t          item_s1;
	logic [SAMPLE_W-1:0] rdata_s1;
	logic                fwd_s1;
	logic [SAMPLE_W-1:0] fwd_data_s1;

	logic                out_valid_q;
	logic [SAMPLE_W-1:0] filtered_q;
	logic                learning_q;

	logic                adv_s1;
	logic [SAMPLE_W-1:0] stored;
	logic [SAMPLE_W-1:0] diff;
	logic [SAMPLE_W-1:0] result;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [SAMPLE_W-1:0] mem_wdata;

	assign clear_busy = clr_busy_q;

	assign adv_s1 = valid_s1 && (!out_valid_q || out_ready);
	assign pop    = q_not_empty && (!valid_s1 || adv_s1);

	// a read issued in the same cycle as the previous write sees old data
	assign stored = fwd_s1 ? fwd_data_s1 : rdata_s1;
	assign diff   = (item_s1.sample >= stored) ? item_s1.sample - stored
		: stored - item_s1.sample;
	assign result = (item_s1.hit && !item_s1.learn) ? diff : item_s1.sample;

	always_comb begin
		if (clr_busy_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = adv_s1 && item_s1.hit;
			mem_waddr = item_s1.addr;
			mem_wdata = item_s1.sample;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_waddr] <= mem_wdata;
		end
		if (pop) begin
			rdata_s1 <= map_mem[q_head.addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1     <= q_head;
			fwd_s1      <= adv_s1 && item_s1.hit && (item_s1.addr == q_head.addr);
			fwd_data_s1 <= item_s1.sample;
		end
		if (adv_s1) begin
			filtered_q <= result;
			learning_q <= item_s1.learn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (32'(clr_addr_q) == MAP_DEPTH - 1) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign filtered_value  = filtered_q;
	assign learning_active = learning_q;

endmodule

[rtl/core/radar_clutter_map_subtract_top.sv]
// top level: clutter map subtraction with apb registers
// path: an accepted input beat passes through the queue, the map read stage and the output register
// throughput: one beat per cycle while out_ready is held high; set by the single map read-modify-write per sample
// reset: learning state and registers reset at once; the map is then zeroed by a
// pass over all 262144 entries (one entry a cycle) during which in_ready stays low
module radar_clutter_map_subtract_top
	import crms_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SAMPLE_W-1:0] sample_value,
	input  logic [BIN_W-1:0]    sample_index,
	input  logic [AZ_W-1:0]     azimuth,
	input  logic [AZ_W-1:0]     reported_bearing,
	input  logic                first_of_sweep,
	input  logic                set_learning,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SAMPLE_W-1:0] filtered_value,
	output logic                learning_active
);

	logic [SIU_W-1:0]    samples_in_use_q;
	logic [LCOUNT_W-1:0] learn_count_q;

	logic       cfg_wr;
	logic       clear_busy;
	logic       q_full;
	logic       q_not_empty;
	logic       push;
	logic       pop;
	crms_item_t push_item;
	crms_item_t q_head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_in_use_q <= SIU_RESET;
			learn_count_q    <= LCOUNT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_SAMPLES_IN_USE: samples_in_use_q <= pwdata[SIU_W-1:0];
				REG_LEARN_COUNT:    learn_count_q    <= pwdata[LCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_SAMPLES_IN_USE: prdata = {{(32-SIU_W){1'b0}}, samples_in_use_q};
			REG_LEARN_COUNT:    prdata = {{(32-LCOUNT_W){1'b0}}, learn_count_q};
			default:            prdata = '0;
		endcase
	end

	crms_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.sample_value     (sample_value),
		.sample_index     (sample_index),
		.azimuth          (azimuth),
		.reported_bearing (reported_bearing),
		.first_of_sweep   (first_of_sweep),
		.set_learning     (set_learning),
		.samples_in_use   (samples_in_use_q),
		.learn_count      (learn_count_q),
		.clear_busy       (clear_busy),
		.q_full           (q_full),
		.push             (push),
		.push_item        (push_item)
	);

	crms_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head_item (q_head)
	);

	crms_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_not_empty     (q_not_empty),
		.q_head          (q_head),
		.pop             (pop),
		.clear_busy      (clear_busy),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.filtered_value  (filtered_value),
		.learning_active (learning_active)
	);

endmodule

[verif/testbench.sv]
// self-checking testbench for the clutter map subtraction block
`timescale 1ns / 1ps

module testbench;
	import crms_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;

	typedef struct {
		logic [SAMPLE_W-1:0] value;
		logic [BIN_W-1:0]    bin;
		logic [AZ_W-1:0]     az;
		logic [AZ_W-1:0]     bearing;
		logic                first;
		logic                learn_req;
	} sweep_sample_t;

	typedef struct {
		logic [SAMPLE_W-1:0] filtered;
		logic                learning;
	} filtered_beat_t;

	typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_t;

	class clutter_scoreboard;
		bit [SAMPLE_W-1:0] map_bytes [MAP_DEPTH];
		bit                learning;
		bit [15:0]         change_count;
		bit [AZ_W-1:0]     prev_az;
		bit [SIU_W-1:0]    siu;
		bit [LCOUNT_W-1:0] lcount;
		filtered_beat_t    pending_filtered [$];
		int unsigned       errors;

		function new();
			learning = 1'b0;
			change_count = '0;
			prev_az = '0;
			siu = SIU_RESET;
			lcount = LCOUNT_RESET;
			errors = 0;
		endfunction

		function void set_register(logic idx, logic [31:0] value);
			case (idx)
				REG_SAMPLES_IN_USE: siu = value[SIU_W-1:0];
				REG_LEARN_COUNT:    lcount = value[LCOUNT_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return pending_filtered.size();
		endfunction

		// runs the learning controller, then the map read-modify-write
		function void note_sample(sweep_sample_t s);
			filtered_beat_t exp_beat;
			int unsigned addr;
			bit [SAMPLE_W-1:0] stored;
			exp_beat.filtered = s.value;
			if (s.first) begin
				if (s.learn_req)
					learning = 1'b1;
				if (learning && prev_az != s.bearing) begin
					change_count = change_count + 16'd1;
					if (change_count >= lcount) begin
						learning = 1'b0;
						change_count = '0;
					end
				end
				prev_az = s.az;
			end
			if (int'(s.bin) < int'(siu) && int'(s.bin) < SAMPLES_PER_ROW &&
					int'(s.az) < AZIMUTH_ROWS) begin
				addr = int'(s.az) * SAMPLES_PER_ROW + int'(s.bin);
				stored = map_bytes[addr];
				if (!learning)
					exp_beat.filtered = (s.value >= stored) ? s.value - stored : stored - s.value;
				map_bytes[addr] = s.value;
			end
			exp_beat.learning = learning;
			pending_filtered.push_back(exp_beat);
		endfunction

		function void check_output(logic [SAMPLE_W-1:0] filtered, logic learn_flag);
			filtered_beat_t exp_beat;
			if (pending_filtered.size() == 0) begin
				$display("%0t: output beat with nothing pending: filtered_value %0h learning_active %0b",
					$time, filtered, learn_flag);
				errors++;
				return;
			end
			exp_beat = pending_filtered.pop_front();
			if (filtered !== exp_beat.filtered) begin
				$display("%0t: filtered_value expected %0h got %0h",
					$time, exp_beat.filtered, filtered);
				errors++;
			end
			if (learn_flag !== exp_beat.learning) begin
				$display("%0t: learning_active expected %0b got %0b",
					$time, exp_beat.learning, learn_flag);
				errors++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [2:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	logic                in_valid;
	logic                in_ready;
	logic [SAMPLE_W-1:0] sample_value;
	logic [BIN_W-1:0]    sample_index;
	logic [AZ_W-1:0]     azimuth;
	logic [AZ_W-1:0]     reported_bearing;
	logic                first_of_sweep;
	logic                set_learning;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [SAMPLE_W-1:0] filtered_value;
	logic                learning_active;

	clutter_scoreboard sb;
	int unsigned cycles = 0;
	rx_mode_t    rx_mode = RX_OPEN;
	int unsigned rx_left = 0;
	int unsigned rx_phase = 0;
	int unsigned burst_left = 0;
	logic [AZ_W-1:0]  last_az = '0;
	logic [SIU_W-1:0] cur_siu = SIU_RESET;

	radar_clutter_map_subtract_top u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.sample_value    (sample_value),
		.sample_index    (sample_index),
		.azimuth         (azimuth),
		.reported_bearing(reported_bearing),
		.first_of_sweep  (first_of_sweep),
		.set_learning    (set_learning),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.filtered_value  (filtered_value),
		.learning_active (learning_active)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// receiver: open, coin-flip or periodic stalls, with the mode picked anew at random intervals
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 2));
			rx_left <= $urandom_range(64, 512);
		end else begin
			rx_left <= rx_left - 1;
		end
		rx_phase <= rx_phase + 1;
		case (rx_mode)
			RX_OPEN:   out_ready <= 1'b1;
			RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
			default:   out_ready <= (rx_phase % 8) >= 3;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
			sb.check_output(filtered_value, learning_active);
	end

	function automatic sweep_sample_t mk(int value, int bin, int az, int bearing,
			bit first, bit req);
		sweep_sample_t s;
		s.value = SAMPLE_W'(value);
		s.bin = BIN_W'(bin);
		s.az = AZ_W'(az);
		s.bearing = AZ_W'(bearing);
		s.first = first;
		s.learn_req = req;
		return s;
	endfunction

	task automatic write_reg(input logic idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_register(idx, value);
		if (idx == REG_SAMPLES_IN_USE)
			cur_siu = value[SIU_W-1:0];
		@(posedge clk);
	endtask

	// present one beat and hold it until accepted, then apply the burst/gap pacing
	task automatic send_sample(input sweep_sample_t s);
		int unsigned gap;
		in_valid <= 1'b1;
		sample_value <= s.value;
		sample_index <= s.bin;
		azimuth <= s.az;
		reported_bearing <= s.bearing;
		first_of_sweep <= s.first;
		set_learning <= s.learn_req;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_sample(s);
		if (s.first)
			last_az = s.az;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(50, 150);
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 20);
				gap = $urandom_range(0, 5);
			end
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input logic [31:0] siu, input logic [31:0] lcount,
			input int unsigned n_items);
		int unsigned sent;
		int unsigned len;
		int unsigned pick;
		logic [AZ_W-1:0]  az;
		logic [AZ_W-1:0]  bearing;
		logic [BIN_W-1:0] start;
		sweep_sample_t s;
		sent = 0;
		drain();
		write_reg(REG_SAMPLES_IN_USE, siu);
		write_reg(REG_LEARN_COUNT, lcount);
		while (sent < n_items) begin
			if ($urandom_range(0, 99) < 15) begin
				// noise beat with every field free
				s.value = SAMPLE_W'($urandom_range(0, 255));
				s.bin = BIN_W'($urandom_range(0, 511));
				s.az = AZ_W'($urandom_range(0, 511));
				s.bearing = AZ_W'($urandom_range(0, 511));
				s.first = 1'($urandom_range(0, 1));
				s.learn_req = 1'($urandom_range(0, 1));
				send_sample(s);
				sent++;
			end else begin
				// small azimuth pool so map entries get revisited
				pick = $urandom_range(0, 99);
				if (pick < 70)
					az = AZ_W'($urandom_range(0, 3));
				else if (pick < 85)
					az = AZ_W'($urandom_range(508, 511));
				else
					az = AZ_W'($urandom_range(0, 511));
				bearing = ($urandom_range(0, 1) == 0) ? last_az : AZ_W'($urandom_range(0, 511));
				pick = $urandom_range(0, 99);
				if (pick < 40)
					start = BIN_W'($urandom_range(0, 8));
				else if (pick < 60)
					start = BIN_W'($urandom_range(500, 511));
				else if (pick < 80)
					start = BIN_W'(int'(cur_siu) - int'($urandom_range(0, 4)));
				else
					start = BIN_W'($urandom_range(0, 511));
				len = $urandom_range(1, 12);
				for (int k = 0; k < len; k++) begin
					s.value = SAMPLE_W'($urandom_range(0, 255));
					s.bin = start + BIN_W'(k);
					s.az = az;
					s.bearing = bearing;
					s.first = (k == 0);
					s.learn_req = (k == 0) ? ($urandom_range(0, 3) == 0)
						: ($urandom_range(0, 7) == 0);
					send_sample(s);
					sent++;
				end
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		sample_value <= '0;
		sample_index <= '0;
		azimuth <= '0;
		reported_bearing <= '0;
		first_of_sweep <= 1'b0;
		set_learning <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// map clearing pass holds in_ready low
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);

		// reset settings: subtract against an all-zero map, then learning entry
		send_sample(mk(8'h00,   0,   0,   0, 1, 0));
		send_sample(mk(8'hff, 511, 511, 511, 1, 0));
		send_sample(mk(8'h80, 511, 511,   0, 0, 0));
		send_sample(mk(8'haa,   0,   0,   0, 0, 0));
		send_sample(mk(8'h55,   0,   0,   0, 0, 1));
		send_sample(mk(8'h3c,   1,   2,   7, 1, 1));
		send_sample(mk(8'hc3,   1,   2,   2, 1, 0));
		send_sample(mk(8'h11,   3,   2,   0, 0, 0));

		// learn count zero and samples_in_use past the row length
		drain();
		write_reg(REG_LEARN_COUNT, 32'd0);
		write_reg(REG_SAMPLES_IN_USE, 32'd1023);
		send_sample(mk(8'h09,   5,   3, 100, 1, 0));
		send_sample(mk(8'hc8, 300,   3,   3, 1, 1));
		send_sample(mk(8'hc8, 511,   3,   0, 0, 0));
		send_sample(mk(8'hc8, 300,   3,   4, 1, 0));
		send_sample(mk(8'h01, 511,   2,   0, 0, 0));

		// nothing filtered
		drain();
		write_reg(REG_SAMPLES_IN_USE, 32'd0);
		send_sample(mk(8'h4d,   0,   0,   0, 1, 0));
		send_sample(mk(8'hfe,   0, 511, 511, 1, 1));
		send_sample(mk(8'h4d,   0,   0, 200, 1, 0));

		run_phase(32'd512,  32'd3,     215);
		run_phase(32'd0,    32'd1,     215);
		run_phase(32'd1023, 32'd0,     215);
		run_phase(32'd137,  32'd7,     215);
		run_phase(32'd1,    32'd65535, 215);
		run_phase(32'd511,  32'd2,     215);
		run_phase(32'd512,  32'd3600,  215);

		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
